@@ design/tkf_pkg.sv @@
// Shared constants, codes and arithmetic helpers of the tilt Kalman filter.
`default_nettype none
package tkf_pkg;

    // Default structure of the block.
    localparam int NUM_FILTERS_DEF  = 4;
    localparam int CORDIC_STEPS_DEF = 16;

    // Register reset values.
    localparam logic [15:0] DT_RST   = 16'd3277;
    localparam logic [23:0] QA_RST   = 24'd16777;
    localparam logic [23:0] QB_RST   = 24'd50332;
    localparam logic [23:0] MEAS_RST = 24'd503316;

    // One in Q8.24.
    localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_DT   = 2'd0,
        REG_QA   = 2'd1,
        REG_QB   = 2'd2,
        REG_MEAS = 2'd3
    } cfg_reg_t;

    // Saturate a wide signed value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
        if (v > 70'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -70'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    // Rescale a product by 2^16, rounding half up.
    function automatic logic signed [67:0] rnd16(input logic signed [67:0] p);
        logic signed [67:0] t;
        t = p + 68'sd32768;
        return t >>> 16;
    endfunction

    // Rescale a product by 2^24, rounding half up.
    function automatic logic signed [67:0] rnd24(input logic signed [67:0] p);
        logic signed [67:0] t;
        t = p + 68'sd8388608;
        return t >>> 24;
    endfunction

    // Arctangent of 2^-i in Q16.16 degrees.
    function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
        case (idx)
            5'd0:    return 32'sd2949120;
            5'd1:    return 32'sd1740967;
            5'd2:    return 32'sd919879;
            5'd3:    return 32'sd466945;
            5'd4:    return 32'sd234379;
            5'd5:    return 32'sd117304;
            5'd6:    return 32'sd58666;
            5'd7:    return 32'sd29335;
            5'd8:    return 32'sd14668;
            5'd9:    return 32'sd7334;
            5'd10:   return 32'sd3667;
            5'd11:   return 32'sd1833;
            5'd12:   return 32'sd917;
            5'd13:   return 32'sd458;
            5'd14:   return 32'sd229;
            5'd15:   return 32'sd115;
            5'd16:   return 32'sd57;
            5'd17:   return 32'sd29;
            5'd18:   return 32'sd14;
            5'd19:   return 32'sd7;
            5'd20:   return 32'sd4;
            5'd21:   return 32'sd2;
            5'd22:   return 32'sd1;
            default: return 32'sd0;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ design/tkf_sqrt.sv @@
// Bit-serial integer floor square root of a 32-bit radicand, one result bit per cycle.
`default_nettype none
module tkf_sqrt import tkf_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] radicand,
    output logic             done,
    output logic [15:0]      root
);

    logic [31:0] rad_reg;
    logic [16:0] rem_reg;
    logic [15:0] root_reg;
    logic [3:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;

    logic [18:0] rem_sh;
    logic [18:0] trial;
    logic        fits;

    // Bring down two radicand bits and try the next root bit.
    assign rem_sh = {rem_reg, rad_reg[31:30]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    // Iteration control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and root.
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (run_reg) begin
            rad_reg  <= {rad_reg[29:0], 2'b00};
            rem_reg  <= fits ? 17'(rem_sh - trial) : rem_sh[16:0];
            root_reg <= {root_reg[14:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

@@ design/tkf_cordic.sv @@
// Vectoring CORDIC that turns (x, y) into an angle in Q16.16 degrees, one step per cycle.
`default_nettype none
module tkf_cordic import tkf_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [15:0]        x_in,
    input  wire logic signed [15:0] y_in,
    output logic                    done,
    output logic signed [31:0]      angle
);

    logic signed [35:0] x_reg, y_reg;
    logic signed [31:0] z_reg;
    logic [4:0]         i_reg;
    logic               run_reg;
    logic               done_reg;

    logic signed [35:0] dx, dy;

    // Shifted cross terms of the current step.
    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                i_reg   <= '0;
            end else if (run_reg) begin
                i_reg <= i_reg + 5'd1;
                if (i_reg == 5'(CORDIC_STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Rotate toward the x axis and accumulate the angle.
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= $signed({4'b0000, x_in, 16'h0000});
            y_reg <= $signed({{4{y_in[15]}}, y_in, 16'h0000});
            z_reg <= '0;
        end else if (run_reg) begin
            if (!y_reg[35]) begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_deg(i_reg);
            end else begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_deg(i_reg);
            end
        end
    end

    assign done  = done_reg;
    assign angle = z_reg;

endmodule
`default_nettype wire

@@ design/tkf_div.sv @@
// Radix-4 restoring divider for the Kalman gain: sat32(trunc(p * 2^24 / s)).
`default_nettype none
module tkf_div import tkf_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [31:0] dividend,
    input  wire logic signed [33:0] divisor,
    output logic                    done,
    output logic signed [31:0]      quotient
);

    logic [55:0]        q_reg;
    logic [32:0]        rem_reg;
    logic [32:0]        d_reg;
    logic               neg_reg;
    logic [4:0]         cnt_reg;
    logic               run_reg;
    logic               fin_reg;
    logic               done_reg;
    logic signed [31:0] quot_reg;

    logic [55:0]        q_next;
    logic [32:0]        rem_next;
    logic [33:0]        t;
    logic [31:0]        p_mag;
    logic [33:0]        s_neg;
    logic signed [69:0] q_signed;

    // Two quotient bits per cycle.
    always_comb begin
        q_next   = q_reg;
        rem_next = rem_reg;
        for (int k = 0; k < 2; k++) begin
            t      = {rem_next, q_next[55]};
            q_next = {q_next[54:0], 1'b0};
            if (t >= {1'b0, d_reg}) begin
                t         = t - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            rem_next = t[32:0];
        end
    end

    // Operand magnitudes and the signed result.
    assign p_mag    = dividend[31] ? (~dividend + 32'd1) : dividend;
    assign s_neg    = -divisor;
    assign q_signed = neg_reg ? -$signed({14'd0, q_reg}) : $signed({14'd0, q_reg});

    // Sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd27) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= {p_mag, 24'h000000};
            rem_reg <= '0;
            d_reg   <= divisor[33] ? s_neg[32:0] : divisor[32:0];
            neg_reg <= dividend[31] ^ divisor[33];
        end else if (run_reg) begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
        if (fin_reg) begin
            quot_reg <= sat32(q_signed);
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

@@ design/tilt_kalman_filter.sv @@
// Top level: pitch from accelerometer by square root and CORDIC, then a two-state Kalman step.
// An update beat runs the square root, the CORDIC arctangent (skipped when accel_x is zero),
// the two gain divisions (skipped when the innovation variance is zero) and the shared
// multiplier sequence. A re-initialize beat, or one for a channel without a filter, gives
// its result on the next cycle. One beat at a time.
// Reset is synchronous, active low: all filters, configuration and sequencer return to their defaults.
`default_nettype none
module tilt_kalman_filter import tkf_pkg::*; #(
    parameter int NUM_FILTERS  = NUM_FILTERS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_rate[79:48]
    input  wire logic [2:0]  s_tuser,   // cmd[0], channel[2:1]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // pitch[31:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam int CH_W = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SQUARE, S_SQRT, S_CORDIC, S_PREDICT, S_DIV0, S_DIV1, S_UPDATE, S_OUT
    } state_t;

    state_t      state_reg;
    logic [3:0]  step_reg;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    // Configuration registers.
    logic [15:0] dt_reg;
    logic [23:0] qa_reg, qb_reg, meas_noise_reg;

    // Filter state.
    logic signed [31:0] angle_mem [NUM_FILTERS];
    logic signed [31:0] bias_mem  [NUM_FILTERS];
    logic signed [31:0] paa_mem   [NUM_FILTERS];
    logic signed [31:0] pab_mem   [NUM_FILTERS];
    logic signed [31:0] pba_mem   [NUM_FILTERS];
    logic signed [31:0] pbb_mem   [NUM_FILTERS];

    // Working registers.
    logic [CH_W-1:0]    ch_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [31:0] gyro_reg, meas_reg;
    logic signed [31:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] k0_reg, k1_reg, y_reg;
    logic signed [33:0] s_reg;
    logic [31:0]        sq_reg;
    logic signed [32:0] mul_a_reg;
    logic signed [34:0] mul_b_reg;
    logic signed [67:0] prod_reg;

    // Input beat fields.
    logic               s_cmd;
    logic [1:0]         s_chan;
    logic [CH_W-1:0]    s_ch_idx;
    logic               s_accept;
    logic               ch_ok;

    assign s_cmd    = s_tuser[0];
    assign s_chan   = s_tuser[2:1];
    assign s_ch_idx = CH_W'(s_chan);
    assign s_accept = s_tvalid && s_tready;
    assign ch_ok    = ({30'd0, s_chan} < 32'(NUM_FILTERS));

    // Rescaled product and other derived values.
    logic signed [67:0] r16, r24;
    logic signed [31:0] rate, y_now, p11_fin, p00_pred;
    logic signed [33:0] s_now;
    logic [31:0]        radicand;

    assign r16      = rnd16(prod_reg);
    assign r24      = rnd24(prod_reg);
    assign rate     = sat32(70'(gyro_reg) - 70'(bias_reg));
    assign y_now    = sat32(70'(meas_reg) - 70'(ang_reg));
    assign p11_fin  = sat32(70'(p11_reg) - 70'(r24));
    assign p00_pred = p00_reg;
    assign s_now    = 34'(p00_pred) + $signed({10'd0, meas_noise_reg});
    assign radicand = sq_reg + prod_reg[31:0];

    // Iterative units.
    logic               sqrt_start, sqrt_done;
    logic [15:0]        sqrt_root;
    logic               cordic_start, cordic_done;
    logic signed [31:0] cordic_angle;
    logic               div_start, div_done;
    logic signed [31:0] div_q;
    logic signed [31:0] div_num;
    logic signed [33:0] div_den;

    assign sqrt_start   = (state_reg == S_SQUARE) && (step_reg == 4'd2);
    assign cordic_start = (state_reg == S_SQRT) && sqrt_done && (ax_reg != 16'sd0);
    assign div_start    = ((state_reg == S_PREDICT) && (step_reg == 4'd8) && (s_now != 34'sd0))
                       || ((state_reg == S_DIV0) && div_done);
    assign div_num      = (state_reg == S_PREDICT) ? p00_reg : p10_reg;
    assign div_den      = (state_reg == S_PREDICT) ? s_now : s_reg;

    tkf_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    tkf_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .x_in    (sqrt_root),
        .y_in    (ax_reg),
        .done    (cordic_done),
        .angle   (cordic_angle)
    );

    tkf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer with the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        step_reg <= '0;
                        if (s_cmd || !ch_ok) begin
                            m_tdata_reg  <= '0;
                            m_tvalid_reg <= 1'b1;
                            state_reg    <= S_OUT;
                        end else begin
                            state_reg <= S_SQUARE;
                        end
                    end
                end
                S_SQUARE: begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd2) begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    step_reg <= '0;
                    if (sqrt_done) begin
                        state_reg <= (ax_reg != 16'sd0) ? S_CORDIC : S_PREDICT;
                    end
                end
                S_CORDIC: begin
                    step_reg <= '0;
                    if (cordic_done) begin
                        state_reg <= S_PREDICT;
                    end
                end
                S_PREDICT: begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd8) begin
                        step_reg  <= '0;
                        state_reg <= (s_now != 34'sd0) ? S_DIV0 : S_UPDATE;
                    end
                end
                S_DIV0: begin
                    if (div_done) begin
                        state_reg <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    step_reg <= '0;
                    if (div_done) begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd7) begin
                        m_tdata_reg  <= ang_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Shared multiplier, registered every cycle.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a_reg * mul_b_reg;
    end

    // Working datapath under the sequencer.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    ch_reg    <= s_ch_idx;
                    ax_reg    <= $signed(s_tdata[15:0]);
                    ay_reg    <= $signed(s_tdata[31:16]);
                    az_reg    <= $signed(s_tdata[47:32]);
                    gyro_reg  <= $signed(s_tdata[79:48]);
                    ang_reg   <= angle_mem[s_ch_idx];
                    bias_reg  <= bias_mem[s_ch_idx];
                    p00_reg   <= paa_mem[s_ch_idx];
                    p01_reg   <= pab_mem[s_ch_idx];
                    p10_reg   <= pba_mem[s_ch_idx];
                    p11_reg   <= pbb_mem[s_ch_idx];
                    mul_a_reg <= 33'($signed(s_tdata[31:16]));
                    mul_b_reg <= 35'($signed(s_tdata[31:16]));
                end
            end
            S_SQUARE: begin
                case (step_reg)
                    4'd0: begin
                        mul_a_reg <= 33'(az_reg);
                        mul_b_reg <= 35'(az_reg);
                    end
                    4'd1: sq_reg <= prod_reg[31:0];
                    default: ;
                endcase
            end
            S_SQRT: begin
                if (sqrt_done && (ax_reg == 16'sd0)) begin
                    meas_reg <= '0;
                end
                mul_a_reg <= $signed({17'd0, dt_reg});
                mul_b_reg <= 35'(rate);
            end
            S_CORDIC: begin
                if (cordic_done) begin
                    meas_reg <= cordic_angle;
                end
                mul_a_reg <= $signed({17'd0, dt_reg});
                mul_b_reg <= 35'(rate);
            end
            S_PREDICT: begin
                case (step_reg)
                    4'd2: begin
                        ang_reg   <= sat32(70'(ang_reg) + 70'(r16));
                        mul_a_reg <= $signed({17'd0, dt_reg});
                        mul_b_reg <= 35'(p11_reg);
                    end
                    4'd4: begin
                        mul_a_reg <= $signed({17'd0, dt_reg});
                        mul_b_reg <= 35'(r16 - 68'(p01_reg) - 68'(p10_reg)
                                         + $signed({44'd0, qa_reg}));
                        p01_reg   <= sat32(70'(p01_reg) - 70'(r16));
                        p10_reg   <= sat32(70'(p10_reg) - 70'(r16));
                    end
                    4'd6: begin
                        p00_reg   <= sat32(70'(p00_reg) + 70'(r16));
                        mul_a_reg <= $signed({9'd0, qb_reg});
                        mul_b_reg <= $signed({19'd0, dt_reg});
                    end
                    4'd8: begin
                        p11_reg <= sat32(70'(p11_reg) + 70'(r16));
                        s_reg   <= s_now;
                        k0_reg  <= '0;
                        k1_reg  <= '0;
                    end
                    default: ;
                endcase
            end
            S_DIV0: begin
                if (div_done) begin
                    k0_reg <= div_q;
                end
            end
            S_DIV1: begin
                if (div_done) begin
                    k1_reg <= div_q;
                end
            end
            S_UPDATE: begin
                case (step_reg)
                    4'd0: begin
                        y_reg     <= y_now;
                        mul_a_reg <= 33'(k0_reg);
                        mul_b_reg <= 35'(y_now);
                    end
                    4'd1: begin
                        mul_a_reg <= 33'(k1_reg);
                        mul_b_reg <= 35'(y_reg);
                    end
                    4'd2: begin
                        ang_reg   <= sat32(70'(ang_reg) + 70'(r24));
                        mul_a_reg <= 33'(k0_reg);
                        mul_b_reg <= 35'(p00_reg);
                    end
                    4'd3: begin
                        bias_reg  <= sat32(70'(bias_reg) + 70'(r24));
                        mul_a_reg <= 33'(k0_reg);
                        mul_b_reg <= 35'(p01_reg);
                    end
                    4'd4: begin
                        p00_reg   <= sat32(70'(p00_reg) - 70'(r24));
                        mul_a_reg <= 33'(k1_reg);
                        mul_b_reg <= 35'(p00_reg);
                    end
                    4'd5: begin
                        p01_reg   <= sat32(70'(p01_reg) - 70'(r24));
                        mul_a_reg <= 33'(k1_reg);
                        mul_b_reg <= 35'(p01_reg);
                    end
                    4'd6: p10_reg <= sat32(70'(p10_reg) - 70'(r24));
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Filter state: re-initialize on command, write back after an update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_FILTERS; c++) begin
                angle_mem[c] <= '0;
                bias_mem[c]  <= '0;
                paa_mem[c]   <= ONE_Q24;
                pab_mem[c]   <= '0;
                pba_mem[c]   <= '0;
                pbb_mem[c]   <= ONE_Q24;
            end
        end else if ((state_reg == S_IDLE) && s_accept && s_cmd && ch_ok) begin
            angle_mem[s_ch_idx] <= '0;
            bias_mem[s_ch_idx]  <= '0;
            paa_mem[s_ch_idx]   <= ONE_Q24;
            pab_mem[s_ch_idx]   <= '0;
            pba_mem[s_ch_idx]   <= '0;
            pbb_mem[s_ch_idx]   <= ONE_Q24;
        end else if ((state_reg == S_UPDATE) && (step_reg == 4'd7)) begin
            angle_mem[ch_reg] <= ang_reg;
            bias_mem[ch_reg]  <= bias_reg;
            paa_mem[ch_reg]   <= p00_reg;
            pab_mem[ch_reg]   <= p01_reg;
            pba_mem[ch_reg]   <= p10_reg;
            pbb_mem[ch_reg]   <= p11_fin;
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg         <= DT_RST;
            qa_reg         <= QA_RST;
            qb_reg         <= QB_RST;
            meas_noise_reg <= MEAS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_DT:   dt_reg         <= cfg_data[15:0];
                REG_QA:   qa_reg         <= cfg_data;
                REG_QB:   qb_reg         <= cfg_data;
                REG_MEAS: meas_noise_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule
`default_nettype wire

@@ design/tkf_checker.sv @@
// Port-level checks of the tilt Kalman filter and their binding to the top level.
`default_nettype none
module tkf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [2:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // A stalled result beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Only one beat is in flight: no input while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // Accepting a beat closes the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready after a beat was accepted");

    // A re-initialize beat returns a zero pitch on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] |=> m_tvalid && (m_tdata == 32'd0))
        else $error("re-initialize did not return zero pitch");

endmodule

bind tilt_kalman_filter tkf_checker u_tkf_checker (.*);
`default_nettype wire
